[hw/rtl/ptzv_pkg.sv]
// ----------------------------------------------------------------------------
// ptzv_pkg
// Shared types and constants of the pan/tilt/zoom command encoder: command
// codes, register indexes, frame bytes and the position handoff structure.
// ----------------------------------------------------------------------------
package ptzv_pkg;

    // Field widths.
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned ANGLE_W = 20;
    localparam int unsigned ZIN_W   = 17;
    localparam int unsigned ZOOM_W  = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned IDX_W   = 4;

    // Input tdata layout, lowest bit first: pan_angle, tilt_angle, zoom_amount.
    // The command code travels in tuser.
    localparam int unsigned IN_TDATA_W = 64;
    localparam int unsigned PAN_LSB    = 0;
    localparam int unsigned TILT_LSB   = PAN_LSB + ANGLE_W;
    localparam int unsigned ZOOM_LSB   = TILT_LSB + ANGLE_W;

    // Rounding of Q8 degrees to ticks at 16 ticks per degree.
    localparam int unsigned TICK_SHIFT = 4;
    localparam logic [21:0] TICK_HALF  = 22'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PT_ABS   = 3'd0,
        CMD_PT_REL   = 3'd1,
        CMD_PAN_ABS  = 3'd2,
        CMD_TILT_ABS = 3'd3,
        CMD_ZOOM_ABS = 3'd4,
        CMD_ZOOM_REL = 3'd5
    } cmd_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_PAN_UPPER  = 3'd0,
        REG_PAN_LOWER  = 3'd1,
        REG_TILT_UPPER = 3'd2,
        REG_TILT_LOWER = 3'd3,
        REG_ZOOM_UPPER = 3'd4,
        REG_ZOOM_LOWER = 3'd5,
        REG_PAN_BIAS   = 3'd6,
        REG_TILT_BIAS  = 3'd7
    } reg_idx_t;

    typedef enum logic {
        FRAME_PAN_TILT = 1'b0,
        FRAME_ZOOM     = 1'b1
    } frame_kind_t;

    // Frame bytes.
    localparam logic [7:0] VISCA_ADDR   = 8'h81;
    localparam logic [7:0] VISCA_CMD    = 8'h01;
    localparam logic [7:0] CAT_PT       = 8'h06;
    localparam logic [7:0] PT_ABS_POS   = 8'h02;
    localparam logic [7:0] PT_PAN_SPEED = 8'h18;
    localparam logic [7:0] PT_TLT_SPEED = 8'h14;
    localparam logic [7:0] CAT_CAM      = 8'h04;
    localparam logic [7:0] ZOOM_DIRECT  = 8'h47;
    localparam logic [7:0] FRAME_END    = 8'hFF;

    localparam logic [IDX_W-1:0] PT_LAST_IDX   = 4'd14;
    localparam logic [IDX_W-1:0] ZOOM_LAST_IDX = 4'd8;

    // Clamped positions handed from the update stage to the framer.
    typedef struct packed {
        frame_kind_t               kind;
        logic signed [ANGLE_W-1:0] pan;
        logic signed [ANGLE_W-1:0] tilt;
        logic signed [ZOOM_W-1:0]  zoom;
    } pos_t;

endpackage

[hw/rtl/ptzv_framer.sv]
// ----------------------------------------------------------------------------
// ptzv_framer
// Converts biased clamped positions to camera ticks and sends the command frame
// one byte per transfer.
// ----------------------------------------------------------------------------
module ptzv_framer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pos_valid,
    output logic                               pos_ready,
    input  ptzv_pkg::pos_t                     pos,
    input  logic signed [ptzv_pkg::ANGLE_W-1:0] pan_bias,
    input  logic signed [ptzv_pkg::ANGLE_W-1:0] tilt_bias,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] frame_byte
    output logic                               m_axis_tlast   // frame_last
);
    import ptzv_pkg::*;

    // Round half away from zero, keep the low 16 bits.
    function automatic logic [TICK_W-1:0] to_ticks(input logic signed [ANGLE_W:0] q8);
        logic [ANGLE_W:0]   mag;
        logic [ANGLE_W-3:0] rnd;
        logic [ANGLE_W-3:0] tck;
        mag = q8[ANGLE_W] ? (ANGLE_W+1)'(-q8) : (ANGLE_W+1)'(q8);
        rnd = (ANGLE_W-2)'(((ANGLE_W+1)'(mag) + TICK_HALF[ANGLE_W:0]) >> TICK_SHIFT);
        tck = q8[ANGLE_W] ? (ANGLE_W-2)'(-rnd) : rnd;
        return tck[TICK_W-1:0];
    endfunction

    logic                  valid_reg, valid_next;
    frame_kind_t           kind_reg;
    logic [TICK_W-1:0]     pan_tick_reg, tilt_tick_reg;
    logic [ZOOM_W-1:0]     zoom_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  is_last;
    logic                  load;
    logic signed [ANGLE_W:0] pan_sum, tilt_sum;

    assign pan_sum  = $signed({pos.pan[ANGLE_W-1], pos.pan})
                    + $signed({pan_bias[ANGLE_W-1], pan_bias});
    assign tilt_sum = $signed({pos.tilt[ANGLE_W-1], pos.tilt})
                    + $signed({tilt_bias[ANGLE_W-1], tilt_bias});

    assign is_last   = (kind_reg == FRAME_ZOOM) ? (idx_reg == ZOOM_LAST_IDX)
                                                : (idx_reg == PT_LAST_IDX);
    assign pos_ready = !valid_reg || (m_axis_tready && is_last);
    assign load      = pos_valid && pos_ready;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && m_axis_tready)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg      <= pos.kind;
            pan_tick_reg  <= to_ticks(pan_sum);
            tilt_tick_reg <= to_ticks(tilt_sum);
            zoom_reg      <= pos.zoom;
        end
    end

    // Byte selection by position within the frame.
    always_comb
    begin
        m_axis_tdata = FRAME_END;
        if (kind_reg == FRAME_ZOOM)
        begin
            case (idx_reg)
                4'd0:    m_axis_tdata = VISCA_ADDR;
                4'd1:    m_axis_tdata = VISCA_CMD;
                4'd2:    m_axis_tdata = CAT_CAM;
                4'd3:    m_axis_tdata = ZOOM_DIRECT;
                4'd4:    m_axis_tdata = {4'h0, zoom_reg[15:12]};
                4'd5:    m_axis_tdata = {4'h0, zoom_reg[11:8]};
                4'd6:    m_axis_tdata = {4'h0, zoom_reg[7:4]};
                4'd7:    m_axis_tdata = {4'h0, zoom_reg[3:0]};
                default: m_axis_tdata = FRAME_END;
            endcase
        end
        else
        begin
            case (idx_reg)
                4'd0:    m_axis_tdata = VISCA_ADDR;
                4'd1:    m_axis_tdata = VISCA_CMD;
                4'd2:    m_axis_tdata = CAT_PT;
                4'd3:    m_axis_tdata = PT_ABS_POS;
                4'd4:    m_axis_tdata = PT_PAN_SPEED;
                4'd5:    m_axis_tdata = PT_TLT_SPEED;
                4'd6:    m_axis_tdata = {4'h0, pan_tick_reg[15:12]};
                4'd7:    m_axis_tdata = {4'h0, pan_tick_reg[11:8]};
                4'd8:    m_axis_tdata = {4'h0, pan_tick_reg[7:4]};
                4'd9:    m_axis_tdata = {4'h0, pan_tick_reg[3:0]};
                4'd10:   m_axis_tdata = {4'h0, tilt_tick_reg[15:12]};
                4'd11:   m_axis_tdata = {4'h0, tilt_tick_reg[11:8]};
                4'd12:   m_axis_tdata = {4'h0, tilt_tick_reg[7:4]};
                4'd13:   m_axis_tdata = {4'h0, tilt_tick_reg[3:0]};
                default: m_axis_tdata = FRAME_END;
            endcase
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = is_last;

endmodule

[hw/rtl/ptz_visca_command_encoder.sv]
// ----------------------------------------------------------------------------
// ptz_visca_command_encoder
// Pan/tilt/zoom command encoder producing VISCA-style camera frames.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, one command per transfer, with the
//   command code in tuser and the angles and zoom amount in tdata. Absolute
//   and relative pan/tilt or zoom commands update the kept camera position,
//   which is clamped to the configured limits. The camera frame leaves on the
//   m_axis channel one byte per transfer, with tlast on the closing 0xFF.
//   A pan/tilt frame has 15 bytes, a zoom frame 9. Commands with codes 6 and 7
//   are dropped and produce no frame.
//   The first byte of a frame appears once the command has passed the input
//   and clamp/update registers into the framer, when the output side is free.
//   Throughput is set by the byte serializer, with the next command's
//   position update overlapping the current frame. The three-stage path
//   (input register, clamp/update register, framer) keeps accepting while a
//   frame is being sent until the stages fill; an output stall simply holds
//   the current byte and backs up the pipeline. Reset clears the kept
//   positions to zero, loads the default limits and biases, and empties all
//   stages. Limits and biases are written through cfg_we/cfg_addr/cfg_data;
//   the user must do so only with no command in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module ptz_visca_command_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [19:0] pan_angle, [39:20] tilt_angle, [56:40] zoom_amount
    input  logic [ptzv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [ptzv_pkg::CMD_W-1:0]        s_axis_tuser,   // [2:0] cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] frame_byte
    output logic                              m_axis_tlast,   // frame_last
    input  logic                              cfg_we,
    input  logic [ptzv_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [ptzv_pkg::CFG_W-1:0]        cfg_data
);
    import ptzv_pkg::*;

    // Configuration registers.
    logic signed [ANGLE_W-1:0] pan_upper_reg, pan_lower_reg;
    logic signed [ANGLE_W-1:0] tilt_upper_reg, tilt_lower_reg;
    logic signed [ZOOM_W-1:0]  zoom_upper_reg, zoom_lower_reg;
    logic signed [ANGLE_W-1:0] pan_bias_reg, tilt_bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_upper_reg  <= 20'sd46080;
            pan_lower_reg  <= -20'sd46080;
            tilt_upper_reg <= 20'sd23040;
            tilt_lower_reg <= -20'sd23040;
            zoom_upper_reg <= 16'sd16384;
            zoom_lower_reg <= '0;
            pan_bias_reg   <= '0;
            tilt_bias_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PAN_UPPER:  pan_upper_reg  <= cfg_data;
                REG_PAN_LOWER:  pan_lower_reg  <= cfg_data;
                REG_TILT_UPPER: tilt_upper_reg <= cfg_data;
                REG_TILT_LOWER: tilt_lower_reg <= cfg_data;
                REG_ZOOM_UPPER: zoom_upper_reg <= cfg_data[ZOOM_W-1:0];
                REG_ZOOM_LOWER: zoom_lower_reg <= cfg_data[ZOOM_W-1:0];
                REG_PAN_BIAS:   pan_bias_reg   <= cfg_data;
                REG_TILT_BIAS:  tilt_bias_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register.
    logic                      in_valid_reg;
    logic [CMD_W-1:0]          in_cmd_reg;
    logic signed [ANGLE_W-1:0] in_pan_reg, in_tilt_reg;
    logic signed [ZIN_W-1:0]   in_zoom_reg;
    logic                      in_accept, in_take, in_bad;

    // Clamp/update stage.
    logic                      pos_valid_reg, pos_valid_next;
    pos_t                      pos_reg, pos_next;
    logic                      pos_ready, pos_free, pos_load;

    // Kept positions.
    logic signed [ANGLE_W-1:0] cur_pan_reg, cur_tilt_reg;
    logic signed [ZOOM_W-1:0]  cur_zoom_reg;

    assign in_bad    = !(in_cmd_reg inside {CMD_PT_ABS, CMD_PT_REL, CMD_PAN_ABS,
                                            CMD_TILT_ABS, CMD_ZOOM_ABS, CMD_ZOOM_REL});
    assign pos_free  = !pos_valid_reg || pos_ready;
    assign in_take   = in_valid_reg && (in_bad || pos_free);
    assign pos_load  = in_valid_reg && !in_bad && pos_free;
    assign s_axis_tready = !in_valid_reg || in_take;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_pan_reg  <= s_axis_tdata[PAN_LSB +: ANGLE_W];
            in_tilt_reg <= s_axis_tdata[TILT_LSB +: ANGLE_W];
            in_zoom_reg <= s_axis_tdata[ZOOM_LSB +: ZIN_W];
        end
    end

    // Target selection. Relative sums are kept one bit wider so they never wrap.
    logic signed [ANGLE_W:0]  pan_tgt, tilt_tgt;
    logic signed [ZOOM_W+1:0] zoom_tgt;
    logic signed [ANGLE_W:0]  pan_hi, pan_lo, tilt_hi, tilt_lo;
    logic signed [ZOOM_W+1:0] zoom_hi, zoom_lo;
    logic signed [ANGLE_W:0]  pan_c1, tilt_c1, pan_c2, tilt_c2;
    logic signed [ZOOM_W+1:0] zoom_c1, zoom_c2;
    logic                     is_zoom;

    always_comb
    begin
        pan_tgt  = $signed({cur_pan_reg[ANGLE_W-1], cur_pan_reg});
        tilt_tgt = $signed({cur_tilt_reg[ANGLE_W-1], cur_tilt_reg});
        zoom_tgt = $signed({in_zoom_reg[ZIN_W-1], in_zoom_reg});
        is_zoom  = 1'b0;
        case (in_cmd_reg)
            CMD_PT_ABS:
            begin
                pan_tgt  = $signed({in_pan_reg[ANGLE_W-1], in_pan_reg});
                tilt_tgt = $signed({in_tilt_reg[ANGLE_W-1], in_tilt_reg});
            end
            CMD_PT_REL:
            begin
                pan_tgt  = $signed({cur_pan_reg[ANGLE_W-1], cur_pan_reg})
                         + $signed({in_pan_reg[ANGLE_W-1], in_pan_reg});
                tilt_tgt = $signed({cur_tilt_reg[ANGLE_W-1], cur_tilt_reg})
                         + $signed({in_tilt_reg[ANGLE_W-1], in_tilt_reg});
            end
            CMD_PAN_ABS:
            begin
                pan_tgt = $signed({in_pan_reg[ANGLE_W-1], in_pan_reg});
            end
            CMD_TILT_ABS:
            begin
                tilt_tgt = $signed({in_tilt_reg[ANGLE_W-1], in_tilt_reg});
            end
            CMD_ZOOM_ABS:
            begin
                is_zoom = 1'b1;
            end
            CMD_ZOOM_REL:
            begin
                is_zoom  = 1'b1;
                zoom_tgt = $signed({{2{cur_zoom_reg[ZOOM_W-1]}}, cur_zoom_reg})
                         + $signed({in_zoom_reg[ZIN_W-1], in_zoom_reg});
            end
            default: ;
        endcase
    end

    // Clamp: upper limit first, then lower limit, so a crossed pair yields lower.
    assign pan_hi  = $signed({pan_upper_reg[ANGLE_W-1], pan_upper_reg});
    assign pan_lo  = $signed({pan_lower_reg[ANGLE_W-1], pan_lower_reg});
    assign tilt_hi = $signed({tilt_upper_reg[ANGLE_W-1], tilt_upper_reg});
    assign tilt_lo = $signed({tilt_lower_reg[ANGLE_W-1], tilt_lower_reg});
    assign zoom_hi = $signed({{2{zoom_upper_reg[ZOOM_W-1]}}, zoom_upper_reg});
    assign zoom_lo = $signed({{2{zoom_lower_reg[ZOOM_W-1]}}, zoom_lower_reg});

    assign pan_c1  = (pan_tgt > pan_hi) ? pan_hi : pan_tgt;
    assign pan_c2  = (pan_c1 < pan_lo) ? pan_lo : pan_c1;
    assign tilt_c1 = (tilt_tgt > tilt_hi) ? tilt_hi : tilt_tgt;
    assign tilt_c2 = (tilt_c1 < tilt_lo) ? tilt_lo : tilt_c1;
    assign zoom_c1 = (zoom_tgt > zoom_hi) ? zoom_hi : zoom_tgt;
    assign zoom_c2 = (zoom_c1 < zoom_lo) ? zoom_lo : zoom_c1;

    always_comb
    begin
        pos_next      = pos_reg;
        pos_next.kind = is_zoom ? FRAME_ZOOM : FRAME_PAN_TILT;
        pos_next.pan  = pan_c2[ANGLE_W-1:0];
        pos_next.tilt = tilt_c2[ANGLE_W-1:0];
        pos_next.zoom = zoom_c2[ZOOM_W-1:0];

        pos_valid_next = pos_valid_reg;
        if (pos_load)
        begin
            pos_valid_next = 1'b1;
        end
        else if (pos_ready)
        begin
            pos_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
            cur_pan_reg   <= '0;
            cur_tilt_reg  <= '0;
            cur_zoom_reg  <= '0;
        end
        else
        begin
            pos_valid_reg <= pos_valid_next;
            if (pos_load)
            begin
                if (is_zoom)
                begin
                    cur_zoom_reg <= pos_next.zoom;
                end
                else
                begin
                    cur_pan_reg  <= pos_next.pan;
                    cur_tilt_reg <= pos_next.tilt;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_load)
        begin
            pos_reg <= pos_next;
        end
    end

    ptzv_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .pos_valid     (pos_valid_reg),
        .pos_ready     (pos_ready),
        .pos           (pos_reg),
        .pan_bias      (pan_bias_reg),
        .tilt_bias     (tilt_bias_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
